>>> sv/svpwm_pkg.sv
// Shared types, constants and the sine table for the SVPWM switch time generator.
`default_nettype none

package svpwm_pkg;

    // PWM period in counts and derived offsets
    localparam int PWM_PERIOD = 2048;
    localparam int HALF_PERIOD = PWM_PERIOD / 2;
    localparam int SQRT3_X16 = 28;
    // 28 * T / 16 folded into one constant multiplier
    localparam int UA_GAIN = SQRT3_X16 * PWM_PERIOD / 16;

    // Table geometry: 512 segments, quarter wave stored
    localparam int TAB_SEG = 512;
    localparam int QTR = TAB_SEG / 4;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Sector pair codes
    localparam logic [1:0] PAIR_14 = 2'd0;
    localparam logic [1:0] PAIR_25 = 2'd1;
    localparam logic [1:0] PAIR_36 = 2'd2;

    typedef logic [31:0] quarter_t [0:QTR];

    // Item passed from the lookup front to the transform back
    typedef struct packed {
        logic signed [31:0] sin_val;
        logic signed [31:0] cos_val;
        logic signed [11:0] volt_d;
        logic signed [11:0] volt_q;
    } item_t;

    // floor(a*b / 2^60)
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        begin
            prod = {64'd0, a} * {64'd0, b};
            return prod[123:60];
        end
    endfunction

    // Taylor series divisor (2k)(2k+1)
    function automatic logic [63:0] series_div(input int k);
        begin
            return 64'((2 * k) * (2 * k + 1));
        end
    endfunction

    // Unsigned quotient by restoring long division, only run while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        begin
            quo = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[63:0], num[b]};
                if (rem >= {1'b0, den})
                begin
                    rem = rem - {1'b0, den};
                    quo[b] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    // Build the quarter wave at elaboration
    function automatic quarter_t build_quarter();
        quarter_t q;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        begin
            for (int i = 0; i <= QTR; i++)
            begin
                x = (PI_Q60 >> 8) * 64'(i);
                x2 = mul_q60(x, x);
                term = x;
                sum = x;
                for (int k = 1; k <= 14; k++)
                begin
                    term = udiv64(mul_q60(term, x2), series_div(k));
                    if ((k & 1) != 0)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                r = (sum + 64'h1000_0000) >> 29;
                if (r > 64'h7FFF_FFFF)
                    r = 64'h7FFF_FFFF;
                q[i] = r[31:0];
            end
            q[0] = 32'd0;
            return q;
        end
    endfunction

    localparam quarter_t SINE_Q = build_quarter();

    // Full table entry j = 0..512 from the quarter wave
    function automatic logic signed [31:0] sine_at(input logic [9:0] j);
        logic [9:0] k;
        logic neg;
        begin
            if (j <= 10'(QTR))
            begin
                k = j;
                neg = 1'b0;
            end
            else if (j <= 10'(2 * QTR))
            begin
                k = 10'(2 * QTR) - j;
                neg = 1'b0;
            end
            else if (j <= 10'(3 * QTR))
            begin
                k = j - 10'(2 * QTR);
                neg = 1'b1;
            end
            else
            begin
                k = 10'(TAB_SEG) - j;
                neg = 1'b1;
            end
            if (neg)
                return -$signed(SINE_Q[k[7:0]]);
            else
                return $signed(SINE_Q[k[7:0]]);
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/svpwm_front.sv
// Front: accepts items, looks up and interpolates sine and cosine.
`default_nettype none

module svpwm_front
    import svpwm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] angle,
    input  wire logic signed [11:0] volt_d,
    input  wire logic signed [11:0] volt_q,
    output logic                    push,
    input  wire logic               full,
    output item_t                   item
);

    logic               v1_reg;
    logic               v2_reg;
    logic               en1;
    logic               en2;
    logic signed [31:0] sa_reg, sb_reg, ca_reg, cb_reg;
    logic [22:0]        frac_reg;
    logic signed [11:0] d1_reg, q1_reg;
    item_t              item_reg;
    item_t              item_next;
    logic [8:0]         idx;
    logic [8:0]         cidx;
    logic signed [32:0] sdiff, cdiff;
    logic signed [56:0] sprod, cprod;
    logic signed [32:0] ssum, csum;

    // Advance each stage when the one after it can take the beat
    assign en2 = !v2_reg || !full;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;
    assign push = v2_reg && !full;
    assign item = item_reg;

    assign idx = angle[31:23];
    assign cidx = idx + 9'(QTR);

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // Fetch the table points around both angles
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            sa_reg   <= sine_at({1'b0, idx});
            sb_reg   <= sine_at({1'b0, idx} + 10'd1);
            ca_reg   <= sine_at({1'b0, cidx});
            cb_reg   <= sine_at({1'b0, cidx} + 10'd1);
            frac_reg <= angle[22:0];
            d1_reg   <= volt_d;
            q1_reg   <= volt_q;
        end
    end

    // Interpolate between the table points
    always_comb
    begin
        sdiff = 33'(sb_reg) - 33'(sa_reg);
        cdiff = 33'(cb_reg) - 33'(ca_reg);
        sprod = 57'(sdiff) * $signed({34'd0, frac_reg});
        cprod = 57'(cdiff) * $signed({34'd0, frac_reg});
        ssum = 33'(sa_reg) + sprod[55:23];
        csum = 33'(ca_reg) + cprod[55:23];
        item_next.sin_val = ssum[31:0];
        item_next.cos_val = csum[31:0];
        item_next.volt_d = d1_reg;
        item_next.volt_q = q1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

>>> sv/svpwm_fifo.sv
// Short queue between the lookup front and the transform back.
`default_nettype none

module svpwm_fifo
    import svpwm_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  item_t     push_item,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output item_t     head,
    output logic [$clog2(DEPTH + 1) - 1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [CW-1:0]  cnt_reg;

    assign full = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head = mem_reg[rd_reg];
    assign count = cnt_reg;

    // Store incoming beats
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> sv/svpwm_back.sv
// Back: inverse Park, X/Y/Z terms, sector decode and compare times.
`default_nettype none

module svpwm_back
    import svpwm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         avail,
    input  item_t             head,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [12:0] time_phase_a,
    output logic signed [12:0] time_phase_b,
    output logic signed [12:0] time_phase_c,
    output logic [1:0]        sector_pair
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    logic signed [12:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [27:0] x_reg, y_reg, z_reg;
    logic signed [12:0] ta_reg, tb_reg, tc_reg;
    logic [1:0]         pair_reg;

    logic signed [12:0] neg_d, neg_q, d13, q13;
    logic signed [44:0] m1, m2, m3, m4;
    logic signed [13:0] alpha, beta;
    logic signed [27:0] ua, xv, sum_uy, dif_uz;
    logic signed [27:0] t0, t1, t2, base;
    logic [1:0]         pair;
    logic               y_neg, z_neg, x_pos;

    // Stall chain from the output register back to the queue
    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pop = avail && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= avail;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // Q31 products; the negated sine is folded into the other operand
    always_comb
    begin
        d13 = 13'(head.volt_d);
        q13 = 13'(head.volt_q);
        neg_d = -d13;
        neg_q = -q13;
        m1 = 45'(neg_d) * 45'(head.cos_val);
        m2 = 45'(neg_q) * 45'(head.sin_val);
        m3 = 45'(q13) * 45'(head.cos_val);
        m4 = 45'(d13) * 45'(head.sin_val);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p1_reg <= m1[43:31];
            p2_reg <= m2[43:31];
            p3_reg <= m3[43:31];
            p4_reg <= m4[43:31];
        end
    end

    // Alpha and beta stay far inside Q31, so saturation never acts
    always_comb
    begin
        alpha = 14'(p1_reg) - 14'(p2_reg);
        beta = 14'(p3_reg) + 14'(p4_reg);
        ua = 28'(alpha) * 28'(UA_GAIN);
        xv = -(28'(beta) <<< 11);
        sum_uy = (ua + xv) >>> 1;
        dif_uz = (xv - ua) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            x_reg <= xv;
            y_reg <= sum_uy;
            z_reg <= dif_uz;
        end
    end

    // Decode the sector pair and form the three compare times
    always_comb
    begin
        y_neg = y_reg[27];
        z_neg = z_reg[27];
        x_pos = !x_reg[27] && (x_reg != '0);
        if (y_neg == z_neg)
        begin
            pair = PAIR_25;
            base = 28'(PWM_PERIOD) + y_reg - z_reg;
            t0 = (base >>> 12) + 28'(HALF_PERIOD);
            t1 = t0 + (z_reg >>> 11);
            t2 = t0 - (y_reg >>> 11);
        end
        else if ((!y_neg && x_pos) || (y_neg && !x_pos))
        begin
            pair = PAIR_14;
            base = 28'(PWM_PERIOD) + x_reg - z_reg;
            t0 = (base >>> 12) + 28'(HALF_PERIOD);
            t1 = t0 + (z_reg >>> 11);
            t2 = t1 - (x_reg >>> 11);
        end
        else
        begin
            pair = PAIR_36;
            base = 28'(PWM_PERIOD) + y_reg - x_reg;
            t0 = (base >>> 12) + 28'(HALF_PERIOD);
            t2 = t0 - (y_reg >>> 11);
            t1 = t2 + (x_reg >>> 11);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            ta_reg   <= t0[12:0];
            tb_reg   <= t1[12:0];
            tc_reg   <= t2[12:0];
            pair_reg <= pair;
        end
    end

    assign out_valid = v3_reg;
    assign time_phase_a = ta_reg;
    assign time_phase_b = tb_reg;
    assign time_phase_c = tc_reg;
    assign sector_pair = pair_reg;

endmodule

`default_nettype wire

>>> sv/svpwm_switch_time_generator_unit.sv
// Top level of the SVPWM switch time generator.
//
//  Channel | Direction | Beat contents (tdata from bit 0 up)
//  s_axis  | in        | angle[31:0], volt_d[43:32], volt_q[55:44]
//  m_axis  | out       | time_phase_a[12:0], _b[25:13], _c[38:26], sector_pair[40:39]
//
// One beat per cycle sustained while m_tready stays high; each beat passes through
// two lookup stages, the queue and three transform stages on its way to the output.
// The interpolation multipliers and the Q31 product stage set the cycle time.
// Reset clears all valid flags and the queue pointers; no clearing pass.
// A stalled output stops the back; the front keeps filling the queue until full.
`default_nettype none

module svpwm_switch_time_generator_unit
    import svpwm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // angle, volt_d, volt_q
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // time_phase_a, time_phase_b, time_phase_c, sector_pair
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_avail;
    item_t              q_in;
    item_t              q_head;
    logic [$clog2(QUEUE_DEPTH + 1) - 1:0] q_count;
    logic signed [12:0] ta, tb, tc;
    logic [1:0]         pair;

    svpwm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .angle    (s_tdata[31:0]),
        .volt_d   (s_tdata[43:32]),
        .volt_q   (s_tdata[55:44]),
        .push     (q_push),
        .full     (q_full),
        .item     (q_in)
    );

    svpwm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_avail),
        .head      (q_head),
        .count     (q_count)
    );

    svpwm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (q_avail),
        .head         (q_head),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .time_phase_a (ta),
        .time_phase_b (tb),
        .time_phase_c (tc),
        .sector_pair  (pair)
    );

    // Pack the result beat
    assign m_tdata = {7'd0, pair, tc, tb, ta};

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_avail)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ($clog2(QUEUE_DEPTH + 1))'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_pair_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pair == PAIR_14 || pair == PAIR_25 || pair == PAIR_36))
        else $error("bad sector pair code");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the SVPWM switch time generator unit.
`default_nettype none

module testbench;
    import svpwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [12:0] ta;
        logic signed [12:0] tb;
        logic signed [12:0] tc;
        logic [1:0]         pair;
    } switch_times_t;

    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    longint sine_tab [0:TAB_SEG];
    switch_times_t expected_times [$];
    int     mismatch_count;
    int     fail_count;
    longint cycle_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off_cycles;

    svpwm_switch_time_generator_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor(a*b / 2^60) on unsigned 64-bit values
    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        begin
            p = {64'd0, a} * {64'd0, b};
            return p[123:60];
        end
    endfunction

    // Build the full sine table by Taylor series
    task automatic fill_sine_table();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        longint r;
        begin
            for (int i = 0; i <= TAB_SEG / 4; i++)
            begin
                x = (PI_Q60 >> 8) * 64'(i);
                x2 = q60_product(x, x);
                term = x;
                sum = x;
                for (int k = 1; k <= 14; k++)
                begin
                    term = q60_product(term, x2) / 64'((2 * k) * (2 * k + 1));
                    if (k & 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                r = longint'((sum + 64'h1000_0000) >> 29);
                if (r > 64'sh7FFF_FFFF)
                    r = 64'sh7FFF_FFFF;
                sine_tab[i] = r;
                sine_tab[TAB_SEG / 2 - i] = r;
                sine_tab[TAB_SEG / 2 + i] = -r;
                sine_tab[TAB_SEG - i] = -r;
            end
            sine_tab[0] = 0;
            sine_tab[TAB_SEG / 2] = 0;
            sine_tab[TAB_SEG] = 0;
        end
    endtask

    function automatic longint lerp_sine(input int idx, input longint frac);
        longint a;
        longint b;
        begin
            a = sine_tab[idx % TAB_SEG];
            b = sine_tab[(idx % TAB_SEG) + 1];
            return a + (((b - a) * frac) >>> 23);
        end
    endfunction

    function automatic longint clamp_q31(input longint v);
        begin
            if (v > 64'sh7FFF_FFFF)
                return 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000)
                return -64'sh8000_0000;
            return v;
        end
    endfunction

    // Compute the compare counts and sector pair for one command
    function automatic switch_times_t predict_switch_times(input logic [31:0] angle,
                                                           input logic [11:0] vd,
                                                           input logic [11:0] vq);
        longint neg_d;
        longint q;
        longint frac;
        longint s;
        longint c;
        longint alpha;
        longint beta;
        longint ua;
        longint x;
        longint y;
        longint z;
        longint t0;
        longint t1;
        longint t2;
        longint t;
        int idx;
        switch_times_t res;
        begin
            t = PWM_PERIOD;
            neg_d = -longint'($signed(vd));
            q = longint'($signed(vq));
            idx = int'(angle[31:23]);
            frac = longint'(angle[22:0]);
            s = lerp_sine(idx, frac);
            c = lerp_sine(idx + TAB_SEG / 4, frac);
            alpha = clamp_q31(((neg_d * c) >>> 31) - ((q * -s) >>> 31));
            beta = clamp_q31(((q * c) >>> 31) + ((neg_d * -s) >>> 31));
            ua = (SQRT3_X16 * t * alpha) >>> 4;
            x = -t * beta;
            y = (ua + x) >>> 1;
            z = (x - ua) >>> 1;
            if ((y >= 0) == (z >= 0))
            begin
                res.pair = PAIR_25;
                t0 = ((t + y - z) >>> 12) + (t >>> 1);
                t1 = t0 + (z >>> 11);
                t2 = t0 - (y >>> 11);
            end
            else if ((y >= 0 && x > 0) || (y < 0 && x <= 0))
            begin
                res.pair = PAIR_14;
                t0 = ((t + x - z) >>> 12) + (t >>> 1);
                t1 = t0 + (z >>> 11);
                t2 = t1 - (x >>> 11);
            end
            else
            begin
                res.pair = PAIR_36;
                t0 = ((t + y - x) >>> 12) + (t >>> 1);
                t2 = t0 - (y >>> 11);
                t1 = t2 + (x >>> 11);
            end
            res.ta = t0[12:0];
            res.tb = t1[12:0];
            res.tc = t2[12:0];
            return res;
        end
    endfunction

    // Send one beat, idling at random first; valid stays up until the next idle
    task automatic send_command(input logic [31:0] angle, input logic [11:0] vd,
                                input logic [11:0] vq);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= {vq, vd, angle};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            expected_times.push_back(predict_switch_times(angle, vd, vq));
        end
    endtask

    // Receiver ready: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        switch_times_t exp_t;
        cycle_count <= cycle_count + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_times.size() == 0)
            begin
                fail_count <= fail_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result beat %h", m_tdata);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                exp_t = expected_times.pop_front();
                if (m_tdata[12:0] !== exp_t.ta || m_tdata[25:13] !== exp_t.tb
                    || m_tdata[38:26] !== exp_t.tc || m_tdata[40:39] !== exp_t.pair)
                begin
                    fail_count <= fail_count + 1;
                    if (mismatch_count < 10)
                        $display({"mismatch: expected a=%0d b=%0d c=%0d pair=%0d,",
                                  " got a=%0d b=%0d c=%0d pair=%0d"},
                                 exp_t.ta, exp_t.tb, exp_t.tc, exp_t.pair,
                                 $signed(m_tdata[12:0]), $signed(m_tdata[25:13]),
                                 $signed(m_tdata[38:26]), m_tdata[40:39]);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Field extremes, zero commands and the quadrant boundaries of the angle
    task automatic test_directed();
        logic [31:0] angles [0:7];
        logic [11:0] volts [0:3];
        begin
            angles = '{32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                       32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0080_0000, 32'h007F_FFFF};
            volts = '{12'h800, 12'h7FF, 12'h000, 12'hFFF};
            for (int i = 0; i < 8; i++)
                send_command(angles[i], volts[i % 4], volts[(i + 1) % 4]);
            for (int i = 0; i < 4; i++)
                send_command(angles[i * 2], volts[i], volts[i]);
            // Zero command hits the equal-sign sector case
            send_command(32'h1234_5678, 12'h000, 12'h000);
            send_command(32'h9ABC_DEF0, 12'h7FF, 12'h800);
        end
    endtask

    task automatic test_random(input int count);
        logic [11:0] vd;
        logic [11:0] vq;
        begin
            for (int i = 0; i < count; i++)
            begin
                vd = 12'($urandom);
                vq = 12'($urandom);
                // Mostly modest commands, some full scale
                if ($urandom_range(3) != 0)
                begin
                    vd = 12'($signed($urandom_range(400)) - 200);
                    vq = 12'($signed($urandom_range(400)) - 200);
                end
                send_command($urandom, vd, vq);
            end
        end
    endtask

    // Hold the receiver off while items keep coming so the input stalls
    task automatic test_backpressure();
        begin
            hold_off_cycles <= 60;
            test_random(30);
        end
    endtask

    initial
    begin
        longint drain_start;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatch_count = 0;
        fail_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 27;
        recv_idle_pct = 60;
        fill_sine_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(280);
        send_idle_pct = 60;
        recv_idle_pct = 27;
        test_random(280);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);

        s_tvalid <= 1'b0;
        drain_start = cycle_count;
        while (expected_times.size() != 0 && cycle_count - drain_start < 5000)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_times.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
